### rtl/plb_pkg.sv
// Shared types and codes for the price level book.
`timescale 1ns / 1ps

package plb_pkg;

  localparam int PRICE_W = 32;
  localparam int QTY_W   = 32;
  localparam int VOL_W   = 48;
  localparam int CNT_W   = 16;
  localparam int RANK_W  = 6;

  localparam logic       KIND_ADD    = 1'b0;
  localparam logic       KIND_CANCEL = 1'b1;
  localparam logic       SIDE_BID    = 1'b0;
  localparam logic       SIDE_ASK    = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  localparam logic [RANK_W-1:0] RANK_MAX = '1;

  // search word walking down the cell chain
  typedef struct packed {
    logic              valid;
    logic              kind;
    logic              side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [RANK_W-1:0]  rank;
    logic              hit;
    logic              removed;
    logic [VOL_W-1:0]   vol;
    logic              hole;
  } token_t;

  // broadcast that opens a new level in one cell
  typedef struct packed {
    logic              en;
    logic              side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } create_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_e;

endpackage

### rtl/plb_cell.sv
// One cell of the chain: a bid level and an ask level plus the search stage.
`timescale 1ns / 1ps

module plb_cell #(
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  plb_pkg::token_t  tok_i,
  input  logic [IW-1:0]    hole_idx_i,
  output plb_pkg::token_t  tok_o,
  output logic [IW-1:0]    hole_idx_o,
  input  plb_pkg::create_t create_i,
  input  logic [IW-1:0]    create_idx_i
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic                         valid_q [2];
  logic [plb_pkg::PRICE_W-1:0] price_q [2];
  logic [plb_pkg::VOL_W-1:0]   total_q [2];
  logic [plb_pkg::CNT_W-1:0]   count_q [2];

  plb_pkg::token_t             tok_d, tok_q;
  logic [IW-1:0]               hole_idx_d, hole_idx_q;

  logic                         v_sel;
  logic [plb_pkg::PRICE_W-1:0] p_sel;
  logic [plb_pkg::VOL_W-1:0]   t_sel;
  logic [plb_pkg::CNT_W-1:0]   c_sel;
  logic                         match, better, upd, do_create;
  logic [plb_pkg::VOL_W:0]     sum;
  logic [plb_pkg::VOL_W-1:0]   total_d;
  logic [plb_pkg::CNT_W-1:0]   count_d;
  logic                         keep_valid;

  assign v_sel = valid_q[tok_i.side];
  assign p_sel = price_q[tok_i.side];
  assign t_sel = total_q[tok_i.side];
  assign c_sel = count_q[tok_i.side];

  assign match  = tok_i.valid && v_sel && (p_sel == tok_i.price);
  assign better = v_sel && ((tok_i.side == plb_pkg::SIDE_BID) ? (p_sel > tok_i.price)
                                                               : (p_sel < tok_i.price));
  assign upd       = match;
  assign do_create = create_i.en && (create_idx_i == MY_IDX);

  always_comb begin
    sum        = {1'b0, t_sel} + {{(plb_pkg::VOL_W + 1 - plb_pkg::QTY_W){1'b0}}, tok_i.qty};
    total_d    = t_sel;
    count_d    = c_sel;
    keep_valid = 1'b1;
    if (tok_i.kind == plb_pkg::KIND_ADD) begin
      total_d = sum[plb_pkg::VOL_W] ? '1 : sum[plb_pkg::VOL_W-1:0];
      if (c_sel != '1) count_d = c_sel + 1'b1;
    end else begin
      total_d = (t_sel > {{(plb_pkg::VOL_W - plb_pkg::QTY_W){1'b0}}, tok_i.qty})
              ? t_sel - {{(plb_pkg::VOL_W - plb_pkg::QTY_W){1'b0}}, tok_i.qty} : '0;
      if (c_sel != '0) count_d = c_sel - 1'b1;
      keep_valid = (count_d != '0);
    end
  end

  always_comb begin
    tok_d      = tok_i;
    hole_idx_d = hole_idx_i;
    tok_d.rank = (tok_i.rank == plb_pkg::RANK_MAX) ? tok_i.rank
               : tok_i.rank + plb_pkg::RANK_W'(better);
    if (match) begin
      tok_d.hit     = 1'b1;
      tok_d.removed = !keep_valid;
      tok_d.vol     = keep_valid ? total_d : '0;
    end
    if (!v_sel && !tok_i.hole) begin
      tok_d.hole = 1'b1;
      hole_idx_d = MY_IDX;
    end
    if (!tok_i.valid) tok_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q      <= '0;
      valid_q[0] <= 1'b0;
      valid_q[1] <= 1'b0;
    end else begin
      tok_q <= tok_d;
      if (upd) valid_q[tok_i.side] <= keep_valid;
      else if (do_create) valid_q[create_i.side] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    hole_idx_q <= hole_idx_d;
    if (upd) begin
      total_q[tok_i.side] <= total_d;
      count_q[tok_i.side] <= count_d;
    end else if (do_create) begin
      price_q[create_i.side] <= create_i.price;
      total_q[create_i.side] <= {{(plb_pkg::VOL_W - plb_pkg::QTY_W){1'b0}}, create_i.qty};
      count_q[create_i.side] <= plb_pkg::CNT_W'(1);
    end
  end

  assign tok_o      = tok_q;
  assign hole_idx_o = hole_idx_q;

endmodule

### rtl/price_level_book.sv
// Top level of the price level book: cell chain, sequencer and result register.
`timescale 1ns / 1ps

// Price level book. Keeps up to MAX_LEVELS price levels per side (bid and ask),
// each with its resting volume (48 bit, saturating) and order count (16 bit,
// saturating). Each input word is an add or a cancel at one price; each yields
// exactly one result word with status, rank from the best price of its side
// (capped at 63; for a cancel taken before removal), the new volume and the
// created/removed flags. The table is a chain of MAX_LEVELS cells, each holding
// one bid and one ask level. A search word walks the chain one cell per cycle,
// counting better levels, updating the matching level on its way, and noting
// the first free cell; a new level is opened in that cell once the walk ends.
// One word is in work at a time: the next word is taken only once the
// sequencer is back in idle after the result is registered, so no new word
// enters the chain before the last one is through. A finished result waits in
// the output register while the next word walks; a walk that ends while that
// register is still stalled holds until it drains.
// After reset all levels are empty; no clearing pass is needed.
module price_level_book #(
  parameter int MAX_LEVELS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic        side_i,
  input  logic [31:0] price_i,
  input  logic [31:0] qty_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [5:0]  level_rank_o,
  output logic [47:0] level_volume_o,
  output logic        level_created_o,
  output logic        level_removed_o
);

  localparam int IW = $clog2(MAX_LEVELS);

  plb_pkg::state_e  state_q, state_d;
  plb_pkg::token_t  tok   [MAX_LEVELS+1];
  logic [IW-1:0]    hidx  [MAX_LEVELS+1];
  plb_pkg::token_t  fin_q;
  logic [IW-1:0]    fin_idx_q;
  plb_pkg::create_t create;
  logic             accept, fire;

  // result word computed from the finished search
  logic [1:0]                  res_status;
  logic [plb_pkg::RANK_W-1:0]  res_rank;
  logic [plb_pkg::VOL_W-1:0]   res_vol;
  logic                        res_created, res_removed;

  logic                        out_valid_q;
  logic [1:0]                  status_q;
  logic [plb_pkg::RANK_W-1:0]  rank_q;
  logic [plb_pkg::VOL_W-1:0]   vol_q;
  logic                        created_q, removed_q;

  assign accept = in_valid_i && !in_stall_o;

  // search word entering the first cell
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = accept;
    tok[0].kind  = kind_i;
    tok[0].side  = side_i;
    tok[0].price = price_i;
    tok[0].qty   = qty_i;
    hidx[0]      = '0;
  end

  for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_cell
    plb_cell #(
      .IW  (IW),
      .IDX (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .tok_i        (tok[g]),
      .hole_idx_i   (hidx[g]),
      .tok_o        (tok[g+1]),
      .hole_idx_o   (hidx[g+1]),
      .create_i     (create),
      .create_idx_i (fin_idx_q)
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      plb_pkg::ST_IDLE:   if (in_valid_i) state_d = plb_pkg::ST_WALK;
      plb_pkg::ST_WALK:   if (tok[MAX_LEVELS].valid) state_d = plb_pkg::ST_FINISH;
      plb_pkg::ST_FINISH: if (fire) state_d = plb_pkg::ST_IDLE;
      default:            state_d = plb_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    fire       = 1'b0;
    case (state_q)
      plb_pkg::ST_IDLE:   in_stall_o = 1'b0;
      plb_pkg::ST_WALK:   in_stall_o = 1'b1;
      plb_pkg::ST_FINISH: fire = !out_valid_q || !out_stall_i;
      default:            in_stall_o = 1'b1;
    endcase
  end

  // decide the outcome of the finished walk
  always_comb begin
    res_status   = plb_pkg::STATUS_OK;
    res_rank     = '0;
    res_vol      = '0;
    res_created  = 1'b0;
    res_removed  = 1'b0;
    create.en    = 1'b0;
    create.side  = fin_q.side;
    create.price = fin_q.price;
    create.qty   = fin_q.qty;
    if (fin_q.hit) begin
      res_rank    = fin_q.rank;
      res_vol     = fin_q.vol;
      res_removed = fin_q.removed;
    end else if (fin_q.kind == plb_pkg::KIND_ADD) begin
      if (fin_q.hole) begin
        res_rank    = fin_q.rank;
        res_vol     = {{(plb_pkg::VOL_W - plb_pkg::QTY_W){1'b0}}, fin_q.qty};
        res_created = 1'b1;
        create.en   = fire;
      end else begin
        res_status = plb_pkg::STATUS_FULL;
      end
    end else begin
      res_status = plb_pkg::STATUS_NOT_FOUND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= plb_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fire) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok[MAX_LEVELS].valid) begin
      fin_q     <= tok[MAX_LEVELS];
      fin_idx_q <= hidx[MAX_LEVELS];
    end
    if (fire) begin
      status_q  <= res_status;
      rank_q    <= res_rank;
      vol_q     <= res_vol;
      created_q <= res_created;
      removed_q <= res_removed;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign level_rank_o    = rank_q;
  assign level_volume_o  = vol_q;
  assign level_created_o = created_q;
  assign level_removed_o = removed_q;

  // a search word only leaves the chain while the sequencer waits for it
  a_walk_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[MAX_LEVELS].valid |-> state_q == plb_pkg::ST_WALK)
    else $error("search word left the chain outside a walk");

  // an accepted word starts a walk
  a_accept_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == plb_pkg::ST_WALK)
    else $error("accepted word did not start a walk");

  // a result is loaded only into a free or draining output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(status_q) && $stable(vol_q))
    else $error("pending result overwritten");

  // failed words report empty fields
  a_fail_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != plb_pkg::STATUS_OK)
      |-> (rank_q == '0 && vol_q == '0 && !created_q && !removed_q))
    else $error("failed word with nonzero fields");

endmodule
